FILE: rtl/image_tile_rect_generator_assert.svh
// Assertion macros used by the top-level RTL.
`ifndef IMAGE_TILE_RECT_GENERATOR_ASSERT_SVH
`define IMAGE_TILE_RECT_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITRG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("itrg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("itrg assertion failed");

`endif

FILE: rtl/itrg_pkg.sv
package itrg_pkg;

    typedef logic [12:0] t_dim;
    typedef logic [11:0] t_off;

    localparam t_dim MAX_DIM = 13'd4096;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_PATCH_WIDTH  = 3'd0;
    localparam logic [2:0] REG_PATCH_HEIGHT = 3'd1;
    localparam logic [2:0] REG_STRIDE_X     = 3'd2;
    localparam logic [2:0] REG_STRIDE_Y     = 3'd3;
    localparam logic [2:0] REG_TILING_MODE  = 3'd4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    localparam logic MODE_SIZE_CONST   = 1'b0;
    localparam logic MODE_STRIDE_CONST = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_CONFIG = 2'd1,
        STATUS_IDLE       = 2'd2
    } t_status;

    typedef struct packed {
        t_dim patch_width;
        t_dim patch_height;
        t_dim stride_x;
        t_dim stride_y;
        logic tiling_mode;
    } t_cfg;

    typedef struct packed {
        logic command;
        t_dim image_width;
        t_dim image_height;
    } t_item;

    typedef struct packed {
        t_off    tile_x;
        t_off    tile_y;
        t_dim    tile_width;
        t_dim    tile_height;
        logic    last_tile;
        t_status status;
    } t_result;

endpackage

FILE: rtl/itrg_cfg_regs.sv
module itrg_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output itrg_pkg::t_cfg      o_cfg
);

    itrg_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.patch_width  <= 13'd64;
            r_cfg.patch_height <= 13'd64;
            r_cfg.stride_x     <= 13'd32;
            r_cfg.stride_y     <= 13'd32;
            r_cfg.tiling_mode  <= itrg_pkg::MODE_SIZE_CONST;
        end else if (wr_en) begin
            case (reg_idx)
                itrg_pkg::REG_PATCH_WIDTH:  r_cfg.patch_width  <= pwdata[12:0];
                itrg_pkg::REG_PATCH_HEIGHT: r_cfg.patch_height <= pwdata[12:0];
                itrg_pkg::REG_STRIDE_X:     r_cfg.stride_x     <= pwdata[12:0];
                itrg_pkg::REG_STRIDE_Y:     r_cfg.stride_y     <= pwdata[12:0];
                itrg_pkg::REG_TILING_MODE:  r_cfg.tiling_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            itrg_pkg::REG_PATCH_WIDTH:  prdata = {19'd0, r_cfg.patch_width};
            itrg_pkg::REG_PATCH_HEIGHT: prdata = {19'd0, r_cfg.patch_height};
            itrg_pkg::REG_STRIDE_X:     prdata = {19'd0, r_cfg.stride_x};
            itrg_pkg::REG_STRIDE_Y:     prdata = {19'd0, r_cfg.stride_y};
            itrg_pkg::REG_TILING_MODE:  prdata = {31'd0, r_cfg.tiling_mode};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/itrg_tile_core.sv
module itrg_tile_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  itrg_pkg::t_item     i_item,
    input  itrg_pkg::t_cfg      i_cfg,
    output itrg_pkg::t_result   o_result
);

    function automatic logic axis_ok(input itrg_pkg::t_dim img, input itrg_pkg::t_dim pat,
                                     input itrg_pkg::t_dim str);
        return (str != 13'd0) && (img >= pat) && (pat >= str) &&
               (img <= itrg_pkg::MAX_DIM) && (pat <= itrg_pkg::MAX_DIM);
    endfunction

    // img >= pat >= str holds wherever the result is used
    function automatic logic axis_last(input itrg_pkg::t_off off, input itrg_pkg::t_dim img,
                                       input itrg_pkg::t_dim pat, input itrg_pkg::t_dim str,
                                       input logic mode);
        if (mode == itrg_pkg::MODE_SIZE_CONST)
            return {1'b0, off} >= (img - pat);
        return {1'b0, off} >= (img - str);
    endfunction

    function automatic itrg_pkg::t_off axis_next(input itrg_pkg::t_off off,
                                                 input itrg_pkg::t_dim img,
                                                 input itrg_pkg::t_dim pat,
                                                 input itrg_pkg::t_dim str,
                                                 input logic mode);
        logic [13:0] sum;
        logic [13:0] lim;
        sum = {2'b00, off} + {1'b0, str};
        lim = {1'b0, img - pat};
        if (mode == itrg_pkg::MODE_SIZE_CONST && sum > lim)
            sum = lim;
        return sum[11:0];
    endfunction

    function automatic itrg_pkg::t_dim axis_size(input itrg_pkg::t_off off,
                                                 input itrg_pkg::t_dim img,
                                                 input itrg_pkg::t_dim pat,
                                                 input logic mode);
        logic [13:0] tile_end;
        logic [13:0] span;
        if (mode == itrg_pkg::MODE_SIZE_CONST)
            return pat;
        if ({1'b0, off} >= img)
            return 13'd0;
        tile_end = {2'b00, off} + {1'b0, pat};
        if (tile_end > {1'b0, img})
            tile_end = {1'b0, img};
        span = tile_end - {2'b00, off};
        return span[12:0];
    endfunction

    itrg_pkg::t_dim r_stored_w, n_stored_w;
    itrg_pkg::t_dim r_stored_h, n_stored_h;
    itrg_pkg::t_off r_cur_x, n_cur_x;
    itrg_pkg::t_off r_cur_y, n_cur_y;
    logic           r_active, n_active;

    itrg_pkg::t_dim img_w, img_h;
    itrg_pkg::t_off ex, ey;
    logic           is_start, cfg_good, emit, cur_last_x, cur_last_y, tile_last;

    always_comb begin
        is_start   = (i_item.command == itrg_pkg::CMD_START);
        img_w      = is_start ? i_item.image_width  : r_stored_w;
        img_h      = is_start ? i_item.image_height : r_stored_h;
        cfg_good   = axis_ok(img_w, i_cfg.patch_width, i_cfg.stride_x) &&
                     axis_ok(img_h, i_cfg.patch_height, i_cfg.stride_y);
        cur_last_x = axis_last(r_cur_x, img_w, i_cfg.patch_width, i_cfg.stride_x,
                               i_cfg.tiling_mode);
        cur_last_y = axis_last(r_cur_y, img_h, i_cfg.patch_height, i_cfg.stride_y,
                               i_cfg.tiling_mode);

        n_stored_w = r_stored_w;
        n_stored_h = r_stored_h;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_active   = r_active;
        emit       = 1'b0;
        ex         = '0;
        ey         = '0;
        o_result   = '0;
        o_result.status = itrg_pkg::STATUS_OK;

        if (is_start) begin
            if (!cfg_good) begin
                o_result.status = itrg_pkg::STATUS_BAD_CONFIG;
                n_active = 1'b0;
            end else begin
                n_stored_w = img_w;
                n_stored_h = img_h;
                emit = 1'b1;
            end
        end else if (!r_active) begin
            o_result.status = itrg_pkg::STATUS_IDLE;
        end else if (!cfg_good) begin
            o_result.status = itrg_pkg::STATUS_BAD_CONFIG;
            n_active = 1'b0;
        end else if (!cur_last_x) begin
            emit = 1'b1;
            ex = axis_next(r_cur_x, img_w, i_cfg.patch_width, i_cfg.stride_x,
                           i_cfg.tiling_mode);
            ey = r_cur_y;
        end else if (!cur_last_y) begin
            emit = 1'b1;
            ey = axis_next(r_cur_y, img_h, i_cfg.patch_height, i_cfg.stride_y,
                           i_cfg.tiling_mode);
        end else begin
            // position already final under the current registers
            o_result.status = itrg_pkg::STATUS_IDLE;
            n_active = 1'b0;
        end

        tile_last = axis_last(ex, img_w, i_cfg.patch_width, i_cfg.stride_x,
                              i_cfg.tiling_mode) &&
                    axis_last(ey, img_h, i_cfg.patch_height, i_cfg.stride_y,
                              i_cfg.tiling_mode);

        if (emit) begin
            n_cur_x = ex;
            n_cur_y = ey;
            n_active = !tile_last;
            o_result.tile_x      = ex;
            o_result.tile_y      = ey;
            o_result.tile_width  = axis_size(ex, img_w, i_cfg.patch_width, i_cfg.tiling_mode);
            o_result.tile_height = axis_size(ey, img_h, i_cfg.patch_height, i_cfg.tiling_mode);
            o_result.last_tile   = tile_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_w <= '0;
            r_stored_h <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_active   <= 1'b0;
        end else if (i_fire) begin
            r_stored_w <= n_stored_w;
            r_stored_h <= n_stored_h;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_active   <= n_active;
        end
    end

endmodule

FILE: rtl/image_tile_rect_generator.sv
// Tile rectangle generator: one result per input item.
// Path: an input transfer loads the input register; when the core fires, the result
// register loads the core result (input register, then result register).
// Throughput: one item per cycle; an output stall backs up through both registers.
// Reset (synchronous, i_rst_n low): pipeline empty, no active sequence, stored size
// and offsets zero, registers 64/64/32/32/size-constant.
module image_tile_rect_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [12:0] i_image_width,
    input  logic [12:0] i_image_height,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_tile_x,
    output logic [11:0] o_tile_y,
    output logic [12:0] o_tile_width,
    output logic [12:0] o_tile_height,
    output logic        o_last_tile,
    output logic [1:0]  o_status
);

`include "image_tile_rect_generator_assert.svh"

    itrg_pkg::t_cfg    cfg;
    itrg_pkg::t_result core_result;

    // input register stage
    logic            r_in_valid;
    itrg_pkg::t_item r_in_item;

    // result register stage
    logic              r_out_valid;
    itrg_pkg::t_result r_out;

    logic fire;      // item in the input register moves through the core
    logic in_take;   // upstream transfer this cycle

    // assertion helpers
    logic out_status_ok;
    logic out_nok;
    logic out_tile_zero;
    logic out_blocked;

    // The core fires when the input register holds an item and the result register is empty or being drained.
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    // Input register can take a new item when it is empty or its item moves on.
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    itrg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    itrg_tile_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.command      <= i_command;
            r_in_item.image_width  <= i_image_width;
            r_in_item.image_height <= i_image_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tile_x      = r_out.tile_x;
    assign o_tile_y      = r_out.tile_y;
    assign o_tile_width  = r_out.tile_width;
    assign o_tile_height = r_out.tile_height;
    assign o_last_tile   = r_out.last_tile;
    assign o_status      = r_out.status;

    assign out_status_ok = (o_status == itrg_pkg::STATUS_OK);
    assign out_nok       = o_out_valid && !out_status_ok;
    assign out_tile_zero = (o_tile_x == 12'd0) && (o_tile_y == 12'd0) &&
                           (o_tile_width == 13'd0) && (o_tile_height == 13'd0) &&
                           !o_last_tile;
    assign out_blocked   = o_out_valid && i_out_stall;

    // Error and idle results carry no tile.
    `ITRG_ASSERT_SAME(a_nok_zero_tile, i_clk, i_rst_n, out_nok, out_tile_zero)
    // A last-tile flag only comes with a good status.
    `ITRG_ASSERT_SAME(a_last_is_ok, i_clk, i_rst_n, o_out_valid && o_last_tile, out_status_ok)
    // Every core fire lands in the result register.
    `ITRG_ASSERT_NEXT(a_fire_to_out, i_clk, i_rst_n, fire, o_out_valid)
    // Upstream is only held off by a blocked item in the input register.
    `ITRG_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_in_valid && out_blocked)

endmodule
